>>> rtl/sdsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdsd_pkg;
    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int SIG_BITS    = 6;
    localparam int LEADER_SETS = 32;
    localparam int ADDR_BITS   = 48;

    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int SIG_N  = 1 << SIG_BITS;
    localparam int SENT_W = SET_W + 1;
    localparam int STR_W  = ADDR_BITS + 1;
    localparam int BLK_W  = 2 + 2 + SIG_BITS;
    localparam int ROW_W  = WAYS * BLK_W;
    localparam int SROW_W = 2 * (ADDR_BITS + STR_W + 2);

    localparam logic [9:0] DUEL_RESET = 10'd512;
    localparam logic [9:0] DUEL_MAX   = 10'd1023;

    typedef enum logic [1:0] {
        CFG_STREAM_THR = 2'd0,
        CFG_REUSE_THR  = 2'd1,
        CFG_CLEAR_INT  = 2'd2,
        CFG_DECAY_INT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_MOD
    } state_t;

    typedef struct packed {
        logic [1:0]          rrpv;
        logic [1:0]          dead;
        logic [SIG_BITS-1:0] sig;
    } blk_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] prev_addr;
        logic [STR_W-1:0]     stride;
        logic [1:0]           count;
    } sent_t;
endpackage
`default_nettype wire

>>> rtl/ship_drrip_stream_dead_replacement_top.sv
// A request passes through the memory read, execute and result register stages before the strobe.
// A new request is accepted only in the idle state, after the previous one has passed read and execute.
// A stream clear or decay walk visits every set, reading it and then writing it back, with busy high.
// An interval register write recomputes the fill remainders bit by bit in the modulo state; busy is high.
// After reset a clearing pass over every set initializes the memories; busy is high.
// The receiver cannot stall; each result strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
module ship_drrip_stream_dead_replacement_top
    import sdsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [10:0] set_index,
    input  wire logic [3:0]  way_index,
    input  wire logic [47:0] address,
    input  wire logic [47:0] program_counter,
    input  wire logic        was_hit,
    input  wire logic        brrip_near,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [3:0]       victim_way,
    output logic             was_streaming,
    output logic [9:0]       duel_counter
);
    state_t state_reg, state_next;

    logic [1:0]  sthr_reg, rthr_reg;
    logic [15:0] sint_reg, dint_reg;
    logic [9:0]  duel_reg, duel_next;
    logic [15:0] fill_reg, fill_next;
    logic [1:0]  outc_reg [SIG_N];
    logic [1:0]  osig_reg, oold_reg;
    logic        clr_pend_reg, clr_pend_next, dec_pend_reg, dec_pend_next;
    logic [SET_W-1:0] walk_reg, walk_next;
    logic [3:0]  mod_bit_reg, mod_bit_next;

    logic             op_reg, hit_reg, near_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [SIG_BITS-1:0]  sig_reg;

    logic             done_reg, done_next;
    logic [3:0]       vic_reg, vic_next;
    logic             strm_reg, strm_next;

    logic              row_we, srow_we;
    logic [SET_W-1:0]  row_raddr, row_waddr;
    logic [ROW_W-1:0]  row_rdata, row_wdata;
    logic [SROW_W-1:0] srow_rdata, srow_wdata;

    sdsd_ram #(.DEPTH(SETS), .WIDTH(ROW_W)) u_blk_ram (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );
    sdsd_ram #(.DEPTH(SETS), .WIDTH(SROW_W)) u_str_ram (
        .clk(clk), .we(srow_we), .waddr(row_waddr), .wdata(srow_wdata),
        .raddr(row_raddr), .rdata(srow_rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE) && !start;
    assign row_raddr  = (state_reg == ST_IDLE) ? set_index[SET_W-1:0] :
                        (state_reg == ST_READ) ? set_reg : walk_reg;
    assign row_waddr  = (state_reg == ST_EXEC) ? set_reg : walk_reg;

    blk_t  b_in [WAYS];
    blk_t  b_out [WAYS];
    sent_t s_in [2];
    sent_t s_out [2];

    logic [1:0]       top;
    logic [1:0]       age;
    logic [1:0]       aged [WAYS];
    logic             found_d, found_a;
    logic [WAY_W-1:0] pick_d, pick_a;
    logic             srl, brl, srrip_sel;
    logic [STR_W-1:0] nstride [2];
    logic             match [2];
    logic             strm;
    logic [1:0]       ins;
    logic [SIG_BITS-1:0] old_sig;
    logic [1:0]       ncount;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            b_in[w] = blk_t'(row_rdata[w*BLK_W +: BLK_W]);
        end
        for (int e = 0; e < 2; e++)
        begin
            s_in[e] = sent_t'(srow_rdata[e*(SROW_W/2) +: SROW_W/2]);
            nstride[e] = {1'b0, addr_reg} - {1'b0, s_in[e].prev_addr};
            match[e] = (s_in[e].stride != '0) && (nstride[e] == s_in[e].stride);
        end
        top = 2'd0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (b_in[w].rrpv > top)
            begin
                top = b_in[w].rrpv;
            end
        end
        age = 2'd3 - top;
        found_d = 1'b0;
        found_a = 1'b0;
        pick_d  = '0;
        pick_a  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            aged[w] = b_in[w].rrpv + age;
            if (aged[w] == 2'd3)
            begin
                found_a = 1'b1;
                pick_a  = WAY_W'(w);
                if (b_in[w].dead == 2'd0)
                begin
                    found_d = 1'b1;
                    pick_d  = WAY_W'(w);
                end
            end
        end

        srl = (set_reg < SET_W'(LEADER_SETS));
        brl = !srl && (set_reg >= SET_W'(SETS - LEADER_SETS));
        srrip_sel = srl || (!brl && (duel_reg >= DUEL_RESET));

        s_out[0] = s_in[0];
        s_out[1] = s_in[1];
        strm = 1'b0;
        ncount = '0;
        priority if (match[0])
        begin
            ncount = (s_in[0].count == 2'd3) ? 2'd3 : s_in[0].count + 2'd1;
            s_out[0].count = ncount;
            s_out[0].prev_addr = addr_reg;
            strm = (ncount >= sthr_reg);
        end
        else if (match[1])
        begin
            ncount = (s_in[1].count == 2'd3) ? 2'd3 : s_in[1].count + 2'd1;
            s_out[1].count = ncount;
            s_out[1].prev_addr = addr_reg;
            strm = (ncount >= sthr_reg);
        end
        else if (s_in[0].prev_addr <= s_in[1].prev_addr)
        begin
            s_out[0] = '{prev_addr: addr_reg, stride: nstride[0], count: 2'd1};
        end
        else
        begin
            s_out[1] = '{prev_addr: addr_reg, stride: nstride[1], count: 2'd1};
        end

        ins = (srrip_sel || near_reg) ? 2'd2 : 2'd3;
        if (strm)
        begin
            ins = 2'd3;
        end
        else if (osig_reg >= rthr_reg)
        begin
            ins = 2'd0;
        end
        old_sig = b_in[way_reg].sig;

        for (int w = 0; w < WAYS; w++)
        begin
            b_out[w] = b_in[w];
        end
        srow_wdata = {s_out[1], s_out[0]};
        if (state_reg == ST_INIT)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                b_out[w] = '{rrpv: 2'd3, dead: 2'd0, sig: '0};
            end
            srow_wdata = '0;
        end
        else if (state_reg == ST_WALK_WR)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (dec_pend_reg && b_in[w].dead != 2'd0)
                begin
                    b_out[w].dead = b_in[w].dead - 2'd1;
                end
            end
            srow_wdata = srow_rdata;
            if (clr_pend_reg)
            begin
                srow_wdata = {s_in[1].prev_addr, s_in[1].stride, 2'd0,
                              s_in[0].prev_addr, s_in[0].stride, 2'd0};
            end
        end
        else if (!op_reg)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                b_out[w].rrpv = aged[w];
            end
        end
        else
        begin
            b_out[way_reg] = '{rrpv: hit_reg ? 2'd0 : ins,
                               dead: (hit_reg || ins == 2'd0) ? 2'd2 : 2'd1,
                               sig: sig_reg};
        end
        for (int w = 0; w < WAYS; w++)
        begin
            row_wdata[w*BLK_W +: BLK_W] = b_out[w];
        end
    end

    logic [15:0] sc_cnt_reg, sc_cnt_next, dc_cnt_reg, dc_cnt_next;
    logic [16:0] sdiv, ddiv;
    logic [16:0] sc_sum, dc_sum;
    logic [16:0] sc_sh, dc_sh;
    logic [15:0] sc_red, dc_red;
    logic [15:0] fill_inc;

    // interval 0 acts as 65536; counters hold fill_reg modulo each interval
    always_comb
    begin
        fill_inc = fill_reg + 16'd1;
        sdiv = {sint_reg == 16'd0, sint_reg};
        ddiv = {dint_reg == 16'd0, dint_reg};
        sc_sum = {1'b0, sc_cnt_reg} + 17'd1;
        dc_sum = {1'b0, dc_cnt_reg} + 17'd1;
        sc_sh = {sc_cnt_reg, fill_reg[mod_bit_reg]};
        dc_sh = {dc_cnt_reg, fill_reg[mod_bit_reg]};
        sc_red = (sc_sh >= sdiv) ? 16'(sc_sh - sdiv) : sc_sh[15:0];
        dc_red = (dc_sh >= ddiv) ? 16'(dc_sh - ddiv) : dc_sh[15:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        mod_bit_next   = mod_bit_reg;
        clr_pend_next  = clr_pend_reg;
        dec_pend_next  = dec_pend_reg;
        duel_next      = duel_reg;
        fill_next      = fill_reg;
        sc_cnt_next    = sc_cnt_reg;
        dc_cnt_next    = dc_cnt_reg;
        done_next      = 1'b0;
        vic_next       = vic_reg;
        strm_next      = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                walk_next = walk_reg + SET_W'(1);
                if (walk_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
                else if (cfg_valid && (cfg_idx_t'(cfg_index) == CFG_CLEAR_INT ||
                                       cfg_idx_t'(cfg_index) == CFG_DECAY_INT))
                begin
                    state_next   = ST_MOD;
                    mod_bit_next = 4'd15;
                    sc_cnt_next  = '0;
                    dc_cnt_next  = '0;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                done_next = 1'b1;
                vic_next  = '0;
                state_next = ST_IDLE;
                if (!op_reg)
                begin
                    vic_next = 4'(found_d ? pick_d : pick_a);
                end
                else if (hit_reg)
                begin
                    if (srl && duel_reg != DUEL_MAX)
                    begin
                        duel_next = duel_reg + 10'd1;
                    end
                    else if (brl && duel_reg != 10'd0)
                    begin
                        duel_next = duel_reg - 10'd1;
                    end
                end
                else
                begin
                    strm_next = strm;
                    fill_next = fill_inc;
                    sc_cnt_next = (fill_inc == 16'd0 || sc_sum == sdiv) ? '0 : sc_sum[15:0];
                    dc_cnt_next = (fill_inc == 16'd0 || dc_sum == ddiv) ? '0 : dc_sum[15:0];
                    clr_pend_next = (sc_cnt_next == 16'd0);
                    dec_pend_next = (dc_cnt_next == 16'd0);
                    if (clr_pend_next || dec_pend_next)
                    begin
                        state_next = ST_WALK_RD;
                        walk_next = '0;
                    end
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_WR;
            end
            ST_WALK_WR:
            begin
                walk_next = walk_reg + SET_W'(1);
                state_next = (walk_reg == SET_W'(SETS - 1)) ? ST_IDLE : ST_WALK_RD;
            end
            ST_MOD:
            begin
                sc_cnt_next  = sc_red;
                dc_cnt_next  = dc_red;
                mod_bit_next = mod_bit_reg - 4'd1;
                if (mod_bit_reg == 4'd0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        row_we  = (state_reg == ST_INIT) || (state_reg == ST_WALK_WR) ||
                  (state_reg == ST_EXEC);
        srow_we = (state_reg == ST_INIT) || (state_reg == ST_WALK_WR) ||
                  (state_reg == ST_EXEC && op_reg && !hit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            walk_reg      <= '0;
            mod_bit_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            dec_pend_reg  <= 1'b0;
            duel_reg      <= DUEL_RESET;
            fill_reg      <= '0;
            sc_cnt_reg    <= '0;
            dc_cnt_reg    <= '0;
            done_reg      <= 1'b0;
            strm_reg      <= 1'b0;
            vic_reg       <= '0;
            osig_reg      <= '0;
            oold_reg      <= '0;
            sthr_reg      <= 2'd3;
            rthr_reg      <= 2'd2;
            sint_reg      <= 16'd4096;
            dint_reg      <= 16'd8192;
            for (int i = 0; i < SIG_N; i++)
            begin
                outc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            mod_bit_reg   <= mod_bit_next;
            clr_pend_reg  <= clr_pend_next;
            dec_pend_reg  <= dec_pend_next;
            duel_reg      <= duel_next;
            fill_reg      <= fill_next;
            sc_cnt_reg    <= sc_cnt_next;
            dc_cnt_reg    <= dc_cnt_next;
            done_reg      <= done_next;
            strm_reg      <= strm_next;
            vic_reg       <= vic_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STREAM_THR: sthr_reg <= cfg_data[1:0];
                    CFG_REUSE_THR:  rthr_reg <= cfg_data[1:0];
                    CFG_CLEAR_INT:  sint_reg <= cfg_data;
                    CFG_DECAY_INT:  dint_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_READ)
            begin
                osig_reg <= outc_reg[sig_reg];
                oold_reg <= outc_reg[old_sig];
            end
            if (state_reg == ST_EXEC && op_reg)
            begin
                if (hit_reg)
                begin
                    if (osig_reg != 2'd3)
                    begin
                        outc_reg[sig_reg] <= osig_reg + 2'd1;
                    end
                end
                else if (ins == 2'd3 && oold_reg != 2'd0)
                begin
                    outc_reg[old_sig] <= oold_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg   <= operation;
            set_reg  <= set_index[SET_W-1:0];
            way_reg  <= way_index[WAY_W-1:0];
            addr_reg <= address;
            hit_reg  <= was_hit;
            near_reg <= brrip_near;
            sig_reg  <= program_counter[SIG_BITS-1:0] ^ address[6 +: SIG_BITS];
        end
    end

    assign done          = done_reg;
    assign victim_way    = vic_reg;
    assign was_streaming = strm_reg;
    assign duel_counter  = duel_reg;
endmodule
`default_nettype wire

>>> rtl/sdsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sdsd_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/sdsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sdsd_checker
    import sdsd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       cfg_ready,
    input wire logic       done,
    input wire logic       was_streaming,
    input wire logic [9:0] duel_counter
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept without busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result while idle");
    a_strm_done: assert property (@(posedge clk) disable iff (!rst_n)
        was_streaming |-> done) else $error("streaming without result");
    a_duel_step: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(duel_counter)) else $error("duel moved silently");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("config while busy");
endmodule

bind ship_drrip_stream_dead_replacement_top sdsd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cfg_ready(cfg_ready), .done(done),
    .was_streaming(was_streaming), .duel_counter(duel_counter)
);
`default_nettype wire
